[rtl/core/srrt_pkg.sv]
// Package for the signal-strength ranked scan table.
// Holds sizes, reset values, register indexes and controller/datapath types.
package srrt_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned AddrW         = 48;
  localparam int unsigned TypeW         = 2;
  localparam int unsigned KeyW          = AddrW + TypeW;
  localparam int unsigned RssiW         = 8;
  localparam int unsigned RankW         = 4;
  localparam int unsigned TotalW        = 5;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 8;

  localparam logic signed [RssiW-1:0] Hysteresis    = 8'sd5;
  localparam logic signed [RssiW-1:0] MinRssiReset  = -8'sd75;
  localparam logic                    ConnOnlyReset = 1'b1;

  localparam logic [CfgIdxW-1:0] RegMinRssi  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegConnOnly = 1'b1;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan_step;
    logic place;
    logic move_step;
    logic move_down;
  } srrt_cmd_t;

  typedef struct packed {
    logic filter_pass;
    logic full;
    logic scan_done;
    logic hit;
    logic needs_move;
    logic move_done;
    logic move_down_done;
  } srrt_sts_t;

endpackage

[rtl/core/srrt_if.sv]
// Valid/ready channel interfaces for the ranked scan table.
// Depends on srrt_pkg for field widths.
interface srrt_req_if;
  import srrt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [AddrW-1:0]        peer_address;
  logic [TypeW-1:0]        address_type;
  logic signed [RssiW-1:0] rssi;
  logic                    connectable;
  modport source (output valid, peer_address, address_type, rssi, connectable, input ready);
  modport sink   (input valid, peer_address, address_type, rssi, connectable, output ready);
endinterface

interface srrt_rsp_if;
  import srrt_pkg::*;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              is_new;
  logic              table_emptied;
  logic [RankW-1:0]  rank;
  logic [TotalW-1:0] entry_total;
  modport source (output valid, accepted, is_new, table_emptied, rank, entry_total, input ready);
  modport sink   (input valid, accepted, is_new, table_emptied, rank, entry_total, output ready);
endinterface

interface srrt_cfg_if;
  import srrt_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/srrt_datapath.sv]
// Datapath of the ranked scan table: request register, entry memory and a shared scan/move pointer.
// Depends on srrt_pkg; driven by srrt_ctrl through command/status structs.
module srrt_datapath #(
  parameter int unsigned TableDepth = srrt_pkg::TableDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srrt_pkg::srrt_cmd_t             cmd_i,
  output srrt_pkg::srrt_sts_t             sts_o,
  input  logic [srrt_pkg::AddrW-1:0]      peer_address_i,
  input  logic [srrt_pkg::TypeW-1:0]      address_type_i,
  input  logic signed [srrt_pkg::RssiW-1:0] rssi_i,
  input  logic                            connectable_i,
  input  logic signed [srrt_pkg::RssiW-1:0] min_rssi_i,
  input  logic                            connect_only_i,
  output logic [srrt_pkg::RankW-1:0]      rank_o,
  output logic [srrt_pkg::TotalW-1:0]     entry_total_o
);
  import srrt_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  logic [KeyW-1:0]        addr_mem [TableDepth];
  logic signed [RssiW-1:0] str_mem [TableDepth];

  logic [KeyW-1:0]         key_q;
  logic signed [RssiW-1:0] rssi_q;
  logic                    conn_q;
  logic [CntW-1:0]         count_q;
  logic [CntW-1:0]         ptr_q;
  logic [IdxW-1:0]         pos;
  logic [IdxW-1:0]         pos_m1;
  logic [IdxW-1:0]         pos_p1;
  logic signed [RssiW:0]   diff;
  logic                    hit;

  assign pos    = ptr_q[IdxW-1:0];
  assign pos_m1 = pos - IdxW'(1);
  assign pos_p1 = pos + IdxW'(1);
  assign hit    = (ptr_q < count_q) && (addr_mem[pos] == key_q);
  assign diff   = {str_mem[pos][RssiW-1], str_mem[pos]} - {rssi_q[RssiW-1], rssi_q};

  assign sts_o.filter_pass = !(rssi_q < min_rssi_i) && !(connect_only_i && !conn_q);
  assign sts_o.full        = (count_q >= CntW'(TableDepth));
  assign sts_o.scan_done   = (ptr_q >= count_q) || hit;
  assign sts_o.hit         = hit;
  assign sts_o.needs_move  = (diff > (RssiW+1)'(Hysteresis)) ||
                             (diff < -((RssiW+1)'(Hysteresis)));
  assign sts_o.move_done   = (ptr_q == '0) || !(str_mem[pos_m1] < str_mem[pos]);
  assign sts_o.move_down_done = ((ptr_q + CntW'(1)) >= count_q) ||
                                !(str_mem[pos_p1] > str_mem[pos]);

  assign rank_o        = RankW'(ptr_q);
  assign entry_total_o = TotalW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        ptr_q <= '0;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end
      if (cmd_i.scan_step) begin
        ptr_q <= ptr_q + CntW'(1);
      end
      if (cmd_i.place && !hit) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.move_step) begin
        ptr_q <= ptr_q - CntW'(1);
      end
      if (cmd_i.move_down) begin
        ptr_q <= ptr_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= {address_type_i, peer_address_i};
      rssi_q <= rssi_i;
      conn_q <= connectable_i;
    end
    if (cmd_i.place) begin
      addr_mem[pos] <= key_q;
      str_mem[pos]  <= rssi_q;
    end
    if (cmd_i.move_step) begin
      addr_mem[pos]    <= addr_mem[pos_m1];
      str_mem[pos]     <= str_mem[pos_m1];
      addr_mem[pos_m1] <= addr_mem[pos];
      str_mem[pos_m1]  <= str_mem[pos];
    end
    if (cmd_i.move_down) begin
      addr_mem[pos]    <= addr_mem[pos_p1];
      str_mem[pos]     <= str_mem[pos_p1];
      addr_mem[pos_p1] <= addr_mem[pos];
      str_mem[pos_p1]  <= str_mem[pos];
    end
  end

endmodule

[rtl/core/srrt_ctrl.sv]
// Controller of the ranked scan table: filter, clear, search, place, bubble up or down, respond.
// Depends on srrt_pkg; commands srrt_datapath.
module srrt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic                accepted_o,
  output logic                is_new_o,
  output logic                emptied_o,
  output logic                rank_zero_o,
  output srrt_pkg::srrt_cmd_t cmd_o,
  input  srrt_pkg::srrt_sts_t sts_i
);
  import srrt_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StFilter, StScan, StMove, StResp
  } state_e;

  state_e state_q, state_d;
  logic   acc_q, acc_d, new_q, new_d, emp_q, emp_d, rz_q, rz_d;

  assign req_ready_o = (state_q == StIdle);
  assign rsp_valid_o = (state_q == StResp);
  assign accepted_o  = acc_q;
  assign is_new_o    = new_q;
  assign emptied_o   = emp_q;
  assign rank_zero_o = rz_q;

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    new_d   = new_q;
    emp_d   = emp_q;
    rz_d    = rz_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StFilter;
        end
      end
      StFilter: begin
        acc_d = sts_i.filter_pass;
        new_d = 1'b0;
        emp_d = 1'b0;
        rz_d  = !sts_i.filter_pass;
        if (sts_i.filter_pass) begin
          if (sts_i.full) begin
            cmd_o.clear = 1'b1;
            emp_d       = 1'b1;
          end
          state_d = StScan;
        end else begin
          state_d = StResp;
        end
      end
      StScan: begin
        if (!sts_i.scan_done) begin
          cmd_o.scan_step = 1'b1;
        end else if (!sts_i.hit) begin
          cmd_o.place = 1'b1;
          new_d       = 1'b1;
          state_d     = StMove;
        end else if (sts_i.needs_move) begin
          cmd_o.place = 1'b1;
          state_d     = StMove;
        end else begin
          state_d = StResp;
        end
      end
      StMove: begin
        if (!sts_i.move_done) begin
          cmd_o.move_step = 1'b1;
        end else if (!sts_i.move_down_done) begin
          cmd_o.move_down = 1'b1;
        end else begin
          state_d = StResp;
        end
      end
      StResp: begin
        if (rsp_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      acc_q   <= 1'b0;
      new_q   <= 1'b0;
      emp_q   <= 1'b0;
      rz_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      new_q   <= new_d;
      emp_q   <= emp_d;
      rz_q    <= rz_d;
    end
  end

endmodule

[rtl/core/scan_report_rssi_ranked_table.sv]
// Top level of the signal-strength ranked scan table.
// Depends on srrt_pkg, srrt_if, srrt_ctrl and srrt_datapath.
//
// Usage:
//   req: one advertising report request (address, type, rssi, connectable).
//   rsp: exactly one result per request (accepted, is_new, table_emptied,
//        rank, entry_total).
//   cfg: register writes, index 0 = min_rssi, index 1 = connect_only;
//        always ready, take effect on the next request.
// Sequence: a rejected report goes from the filter step straight to the
//   response. An accepted report first empties a full table, searches the
//   stored entries for its key, is written at the hit or at the end, then
//   moves up or down by a one-place-per-cycle compare/swap over the entry
//   memory. A stored report that needs no move is answered without a write.
// One request is handled at a time; req.ready is low from acceptance until
//   the response is taken. A stalled rsp holds its payload and the block.
// Reset empties the table and loads min_rssi = -75 and connect_only = 1.
module scan_report_rssi_ranked_table #(
  parameter int unsigned TableDepth = srrt_pkg::TableDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  srrt_req_if.sink   req,
  srrt_rsp_if.source rsp,
  srrt_cfg_if.sink   cfg
);
  import srrt_pkg::*;

  srrt_cmd_t               cmd;
  srrt_sts_t               sts;
  logic signed [RssiW-1:0] min_rssi_q;
  logic                    conn_only_q;
  logic                    rank_zero;
  logic [RankW-1:0]        dp_rank;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rssi_q  <= MinRssiReset;
      conn_only_q <= ConnOnlyReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegMinRssi:  min_rssi_q  <= cfg.data;
        RegConnOnly: conn_only_q <= cfg.data[0];
        default: ;
      endcase
    end
  end

  srrt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .accepted_o  (rsp.accepted),
    .is_new_o    (rsp.is_new),
    .emptied_o   (rsp.table_emptied),
    .rank_zero_o (rank_zero),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  srrt_datapath #(.TableDepth(TableDepth)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i          (cmd),
    .sts_o          (sts),
    .peer_address_i (req.peer_address),
    .address_type_i (req.address_type),
    .rssi_i         (req.rssi),
    .connectable_i  (req.connectable),
    .min_rssi_i     (min_rssi_q),
    .connect_only_i (conn_only_q),
    .rank_o         (dp_rank),
    .entry_total_o  (rsp.entry_total)
  );

  assign rsp.rank = rank_zero ? '0 : dp_rank;

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.scan_step, cmd.place, cmd.move_step, cmd.move_down, cmd.load}) <= 1)
    else $error("conflicting datapath commands");
  a_rsp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready)
    else $error("request taken while response pending");
  a_new_means_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && (rsp.is_new || rsp.table_emptied) |-> rsp.accepted)
    else $error("new or emptied without acceptance");

endmodule
